// ===== hdl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial line editor package
// Shared types, constants and character helpers for the serial line editor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  // Line buffer sizing; one slot is held back, so ROOM bytes can be stored.
  localparam int LINE_SIZE = 32;
  localparam int ROOM      = LINE_SIZE - 1;
  localparam int FILL_W    = $clog2(LINE_SIZE);
  localparam int ADDR_W    = (ROOM > 1) ? $clog2(ROOM) : 1;
  localparam int LEN_W     = 5;

  // Character codes.
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd1;
  localparam logic [1:0] CFG_ACCEPT_ANGLE   = 2'd2;

  // Request types.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_LINE    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_CMP,
    S_ECHO,
    S_LF,
    S_SPACE,
    S_BS,
    S_LWAIT,
    S_LOUT,
    S_DONE,
    S_TOUT
  } state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } sle_in_t;

  typedef struct packed {
    kind_t            out_kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;
  } sle_out_t;

  // True for the characters that go into the line buffer.
  function automatic logic is_accepted(input logic [7:0] c, input logic angle_en);
    logic res;
    res = (c == CH_SPACE) || (c == CH_DASH) ||
          (c >= 8'h30 && c <= 8'h39) ||
          (c >= 8'h41 && c <= 8'h5a) ||
          (c >= 8'h61 && c <= 8'h7a) ||
          (((c == CH_LT) || (c == CH_GT)) && angle_en);
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sle_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// Serial line editor
// Terminal line discipline with echo, line buffer and line timeout.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel is a received byte or a millisecond
// tick. Results (echo bytes, line bytes, line done, timeout) leave on the out_
// channel, one per accepted transfer; the final result of a request has last
// set. A request that causes nothing produces no result.
// Registers are written through the cfg_ channel (always ready); the user must
// write them only while idle, as the block itself does not enforce it.
// A request is taken only in the idle state and is first registered; each
// result is then offered from the result register. A stored line byte passes
// through a wait state before it is offered, because the line buffer RAM has
// a registered read port. A tick does a saturating increment, then the compare
// against the limit, then offers a timeout result if the limit is exceeded.
// When the receiver stalls, the result register holds and the sequencer waits.
// Reset clears the state machine, fill index, tick count and registers; the
// line buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_line_editor (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sle_pkg::sle_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sle_pkg::sle_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  sle_pkg::state_t                 state_r, state_nxt;
  logic [sle_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [sle_pkg::FILL_W-1:0]      k_r, k_nxt;
  logic [31:0]                     elapsed_r, elapsed_nxt;
  logic [7:0]                      byte_r, byte_nxt;
  logic                            lf_r, lf_nxt;
  logic                            bsp_r, bsp_nxt;
  logic                            line_r, line_nxt;
  logic                            out_valid_r, out_valid_nxt;
  sle_pkg::sle_out_t               out_data_r, out_data_nxt;
  logic                            tout_en_r;
  logic [31:0]                     tout_ticks_r;
  logic                            angle_en_r;

  logic                            in_accept;
  logic                            out_free;
  logic [7:0]                      c;
  logic                            has_room;
  logic                            is_bs;
  logic                            is_cr;
  logic                            is_eol;
  logic                            do_echo;
  logic                            do_lf;
  logic                            do_store;
  logic                            do_bsp;
  logic                            do_line;
  logic [sle_pkg::FILL_W-1:0]      k_inc;
  logic                            k_done;
  logic [7:0]                      rd_byte;
  sle_pkg::state_t                 line_start;
  sle_pkg::state_t                 after_echo;

  assign in_stall  = (state_r != sle_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Byte decode against the current fill index.
  assign c        = in_data.rx_byte;
  assign has_room = (fill_r < sle_pkg::FILL_W'(sle_pkg::ROOM));
  assign is_bs    = (c == sle_pkg::CH_BS) || (c == sle_pkg::CH_DEL);
  assign is_cr    = (c == sle_pkg::CH_CR);
  assign is_eol   = is_cr || (c == sle_pkg::CH_LF);
  assign do_echo  = has_room ? !((fill_r == '0) && is_bs) : (c == sle_pkg::CH_DEL);
  assign do_lf    = has_room && is_cr;
  assign do_store = has_room && sle_pkg::is_accepted(c, angle_en_r);
  assign do_bsp   = !do_store && is_bs && (fill_r != '0);
  assign do_line  = !do_store && !do_bsp && is_eol;

  // Line walk counter.
  assign k_inc  = k_r + 1'b1;
  assign k_done = (k_inc >= fill_r);

  // Where the line output begins, and what follows the echo of the byte.
  assign line_start = (fill_r != '0) ? sle_pkg::S_LWAIT : sle_pkg::S_DONE;
  always_comb begin
    if (bsp_r) begin
      after_echo = sle_pkg::S_SPACE;
    end else if (line_r) begin
      after_echo = line_start;
    end else begin
      after_echo = sle_pkg::S_IDLE;
    end
  end

  // Line buffer.
  sle_ram #(
    .WIDTH (8),
    .DEPTH (sle_pkg::ROOM)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (in_accept && (in_data.req_type == sle_pkg::REQ_BYTE) && do_store),
    .wr_addr (fill_r[sle_pkg::ADDR_W-1:0]),
    .wr_data (c),
    .rd_addr (k_r[sle_pkg::ADDR_W-1:0]),
    .rd_data (rd_byte)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sle_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_data.req_type == sle_pkg::REQ_TICK) begin
            state_nxt = sle_pkg::S_TICK_CMP;
          end else if (do_echo) begin
            state_nxt = sle_pkg::S_ECHO;
          end else if (do_bsp) begin
            state_nxt = sle_pkg::S_SPACE;
          end else if (do_line) begin
            state_nxt = line_start;
          end
        end
      end
      sle_pkg::S_TICK_CMP: begin
        if (tout_en_r && (elapsed_r > tout_ticks_r)) begin
          state_nxt = sle_pkg::S_TOUT;
        end else begin
          state_nxt = sle_pkg::S_IDLE;
        end
      end
      sle_pkg::S_ECHO: begin
        if (out_free) begin
          state_nxt = lf_r ? sle_pkg::S_LF : after_echo;
        end
      end
      sle_pkg::S_LF: begin
        if (out_free) begin
          state_nxt = line_r ? line_start : sle_pkg::S_IDLE;
        end
      end
      sle_pkg::S_SPACE: begin
        if (out_free) begin
          state_nxt = sle_pkg::S_BS;
        end
      end
      sle_pkg::S_LWAIT: begin
        state_nxt = sle_pkg::S_LOUT;
      end
      sle_pkg::S_LOUT: begin
        if (out_free) begin
          state_nxt = k_done ? sle_pkg::S_DONE : sle_pkg::S_LWAIT;
        end
      end
      sle_pkg::S_BS, sle_pkg::S_DONE, sle_pkg::S_TOUT: begin
        if (out_free) begin
          state_nxt = sle_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sle_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath updates and result generation.
  always_comb begin
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    elapsed_nxt   = elapsed_r;
    byte_nxt      = byte_r;
    lf_nxt        = lf_r;
    bsp_nxt       = bsp_r;
    line_nxt      = line_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      sle_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_data.req_type == sle_pkg::REQ_TICK) begin
            if (elapsed_r != '1) begin
              elapsed_nxt = elapsed_r + 32'd1;
            end
          end else begin
            // The byte is kept, since the sender may move on once it is taken.
            byte_nxt = c;
            lf_nxt   = do_lf;
            bsp_nxt  = do_bsp;
            line_nxt = do_line;
            k_nxt    = '0;
            if (do_store) begin
              fill_nxt = fill_r + 1'b1;
            end
            if (do_bsp) begin
              fill_nxt = fill_r - 1'b1;
            end
            if (do_line) begin
              elapsed_nxt = '0;
            end
          end
        end
      end
      sle_pkg::S_ECHO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sle_pkg::KIND_ECHO, byte_r, '0, !lf_r && !bsp_r && !line_r};
        end
      end
      sle_pkg::S_LF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sle_pkg::KIND_ECHO, sle_pkg::CH_LF, '0, !line_r};
        end
      end
      sle_pkg::S_SPACE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sle_pkg::KIND_ECHO, sle_pkg::CH_SPACE, '0, 1'b0};
        end
      end
      sle_pkg::S_BS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sle_pkg::KIND_ECHO, sle_pkg::CH_BS, '0, 1'b1};
        end
      end
      sle_pkg::S_LOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sle_pkg::KIND_LINE, rd_byte, '0, 1'b0};
          k_nxt         = k_inc;
        end
      end
      sle_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sle_pkg::KIND_DONE, 8'd0, sle_pkg::LEN_W'(fill_r), 1'b1};
          fill_nxt      = '0;
        end
      end
      sle_pkg::S_TOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sle_pkg::KIND_TIMEOUT, 8'd0, '0, 1'b1};
          fill_nxt      = '0;
          elapsed_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sle_pkg::S_IDLE;
      fill_r      <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-request flags, walk counter and result payload.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    byte_r     <= byte_nxt;
    lf_r       <= lf_nxt;
    bsp_r      <= bsp_nxt;
    line_r     <= line_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tout_en_r    <= 1'b0;
      tout_ticks_r <= '0;
      angle_en_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sle_pkg::CFG_TIMEOUT_ENABLE: tout_en_r    <= cfg_data[0];
        sle_pkg::CFG_TIMEOUT_TICKS:  tout_ticks_r <= cfg_data;
        sle_pkg::CFG_ACCEPT_ANGLE:   angle_en_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sle_chk.sv =====
// ----------------------------------------------------------------------------
// Serial line editor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sle_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire sle_pkg::sle_out_t out_data
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Line done and timeout always close a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.out_kind == sle_pkg::KIND_DONE ||
                  out_data.out_kind == sle_pkg::KIND_TIMEOUT) |-> out_data.last)
    else $error("done or timeout without last");

  // A line byte is never marked last; line done follows it.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == sle_pkg::KIND_LINE |-> !out_data.last)
    else $error("line byte marked last");

  // Length is reported only with line done.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind != sle_pkg::KIND_DONE |-> out_data.line_length == '0)
    else $error("line length outside line done");

endmodule

bind serial_line_editor sle_chk u_sle_chk (.*);

`default_nettype wire

// ===== bench/tb_serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// Serial line editor testbench
// Drives received bytes and millisecond ticks into the editor under several
// register settings. Every result is checked against a cycle-free model of the
// echo, line store and timeout behavior. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_serial_line_editor;
  import sle_pkg::*;

  // Model of the editor: register copies, line store, and the results still owed.
  class line_checker;
    logic        timeout_on;
    logic [31:0] timeout_limit;
    logic        angle_on;
    logic [7:0]  line_buf [ROOM];
    int unsigned fill;
    logic [31:0] ticks_seen;
    sle_out_t    owed_results [$];
    int unsigned fail_count;

    function new();
      timeout_on    = 1'b0;
      timeout_limit = '0;
      angle_on      = 1'b1;
      fill          = 0;
      ticks_seen    = '0;
      fail_count    = 0;
    endfunction

    function void set_register(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
        CFG_TIMEOUT_ENABLE: timeout_on    = val[0];
        CFG_TIMEOUT_TICKS:  timeout_limit = val;
        CFG_ACCEPT_ANGLE:   angle_on      = val[0];
        default: ;
      endcase
    endfunction

    // Characters that the editor keeps in the line.
    function bit storable(input logic [7:0] c);
      logic [7:0] folded;
      // Setting bit 5 maps upper case letters onto lower case ones.
      folded = c | 8'h20;
      if (c == CH_LT || c == CH_GT)
        return angle_on;
      if (c == CH_SPACE || c == CH_DASH)
        return 1'b1;
      return (c >= 8'h30 && c <= 8'h39) || (folded >= 8'h61 && folded <= 8'h7a);
    endfunction

    function void owe(input kind_t kind, input logic [7:0] ch, input logic [LEN_W-1:0] len);
      sle_out_t r;
      r.out_kind    = kind;
      r.out_byte    = ch;
      r.line_length = len;
      r.last        = 1'b0;
      owed_results.push_back(r);
    endfunction

    // Works out the results of one accepted request; returns how many it causes.
    function int unsigned note_request(input sle_in_t req);
      int unsigned first;
      logic [7:0]  c;
      logic        erase;
      sle_out_t    tail;
      first = owed_results.size();
      c     = req.rx_byte;
      erase = (c == CH_BS) || (c == CH_DEL);
      if (req.req_type == REQ_TICK) begin
        if (ticks_seen != 32'hffff_ffff)
          ticks_seen++;
        if (timeout_on && ticks_seen > timeout_limit) begin
          owe(KIND_TIMEOUT, 8'h00, '0);
          fill       = 0;
          ticks_seen = '0;
        end
      end else begin
        // Echo first: a full line echoes only DEL.
        if (fill < ROOM) begin
          if (!(fill == 0 && erase)) begin
            owe(KIND_ECHO, c, '0);
            if (c == CH_CR)
              owe(KIND_ECHO, CH_LF, '0);
          end
        end else if (c == CH_DEL) begin
          owe(KIND_ECHO, c, '0);
        end
        // Then the line edit itself.
        if (fill < ROOM && storable(c)) begin
          line_buf[fill] = c;
          fill++;
        end else if (erase && fill > 0) begin
          fill--;
          owe(KIND_ECHO, CH_SPACE, '0);
          owe(KIND_ECHO, CH_BS, '0);
        end else if (c == CH_CR || c == CH_LF) begin
          for (int unsigned k = 0; k < fill; k++)
            owe(KIND_LINE, line_buf[k], '0);
          owe(KIND_DONE, 8'h00, LEN_W'(fill));
          fill       = 0;
          ticks_seen = '0;
        end
      end
      if (owed_results.size() > first) begin
        tail      = owed_results.pop_back();
        tail.last = 1'b1;
        owed_results.push_back(tail);
      end
      return owed_results.size() - first;
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(input sle_out_t got);
      sle_out_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d byte %h len %0d",
                 $time, got.out_kind, got.out_byte, got.line_length);
        fail_count++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("out_kind", want.out_kind, got.out_kind);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("line_length", want.line_length, got.line_length);
      compare_field("last", want.last, got.last);
    endfunction

    function int unsigned owed_count();
      return owed_results.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  sle_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sle_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_TIMEOUT_ENABLE;
  logic [31:0] cfg_data  = '0;

  logic        quiet = 1'b0;
  int unsigned sent_requests = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  line_checker line_model = new();

  serial_line_editor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Receiver back-pressure: random stall bursts, with calm stretches.
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left != 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 39) == 0)
        calm_left = $urandom_range(30, 100);
      out_stall <= 1'b0;
    end
  end

  // Every accepted result goes to the checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      line_model.check_result(out_data);
  end

  function automatic sle_in_t byte_req(input logic [7:0] c);
    sle_in_t r;
    r.req_type = REQ_BYTE;
    r.rx_byte  = c;
    return r;
  endfunction

  // The byte field of a tick is ignored, so it carries noise.
  function automatic sle_in_t tick_req();
    sle_in_t r;
    r.req_type = REQ_TICK;
    r.rx_byte  = 8'($urandom);
    return r;
  endfunction

  function automatic sle_in_t random_req();
    sle_in_t r;
    r.req_type = 1'($urandom_range(0, 1));
    r.rx_byte  = 8'($urandom);
    return r;
  endfunction

  // A character that a line normally holds; angle brackets depend on the setting.
  function automatic logic [7:0] pick_line_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h41, 8'h5a));
      1: return 8'($urandom_range(8'h61, 8'h7a));
      2: return 8'($urandom_range(8'h30, 8'h39));
      3: return CH_SPACE;
      4: return CH_DASH;
      default: return $urandom_range(0, 1) ? CH_LT : CH_GT;
    endcase
  endfunction

  // Presents one request, with an occasional gap before it, and waits for acceptance.
  task automatic send_request(input sle_in_t req);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(line_model.note_request(req));
    sent_requests++;
  endtask

  // Holds off the sender until the editor has delivered everything owed.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_model.owed_count() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Writes all three registers; the editor must be idle.
  task automatic program_editor(input logic en, input logic [31:0] limit, input logic angle);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx = '{CFG_TIMEOUT_ENABLE, CFG_TIMEOUT_TICKS, CFG_ACCEPT_ANGLE};
    val = '{{31'd0, en}, limit, {31'd0, angle}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      line_model.set_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // A typed line with some edits, ticks and stray bytes, closed by CR or LF.
  task automatic send_line(input int unsigned len);
    int unsigned roll;
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 12)
        send_request(byte_req($urandom_range(0, 1) ? CH_BS : CH_DEL));
      else if (roll < 18)
        send_request(tick_req());
      else if (roll < 22)
        send_request(byte_req(8'($urandom)));
      else
        send_request(byte_req(pick_line_char()));
    end
    send_request(byte_req($urandom_range(0, 1) ? CH_CR : CH_LF));
  endtask

  // Mostly well-formed lines, with tick bursts, noise and an occasional full drain.
  task automatic run_random(input int unsigned target);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = sent_requests + target;
    while (sent_requests < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 6)
        send_line($urandom_range(29, 38));
      else if (roll < 60)
        send_line($urandom_range(0, 12));
      else if (roll < 78)
        repeat ($urandom_range(1, 8)) send_request(tick_req());
      else if (roll < 96)
        repeat ($urandom_range(1, 6)) send_request(random_req());
      else if (!quiet)
        drain_results();
    end
  endtask

  initial begin
    logic [7:0] opening [13];
    opening = '{8'h41, 8'h7a, 8'h30, 8'h39, CH_SPACE, CH_DASH, CH_LT, CH_GT,
                CH_BS, CH_DEL, 8'hff, 8'h80, 8'h00};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no timeout, angle brackets stored.
    program_editor(1'b0, 32'd0, 1'b1);
    // Field extremes, erasing, bytes that are only echoed, then CR with its LF echo.
    foreach (opening[i])
      send_request(byte_req(opening[i]));
    send_request(tick_req());
    send_request(byte_req(CH_CR));
    // Erase on an empty line, then a short line and an empty line ended by LF.
    send_request(byte_req(CH_BS));
    send_request(byte_req(CH_DEL));
    send_request(byte_req(8'h5a));
    send_request(byte_req(8'h61));
    send_request(byte_req(CH_LF));
    send_request(byte_req(CH_LF));
    // Full line: extra bytes are dropped, only DEL echoes, erase still works.
    repeat (ROOM) send_request(byte_req(pick_line_char()));
    send_request(byte_req(8'h71));
    send_request(byte_req(CH_BS));
    send_request(byte_req(CH_DEL));
    send_request(byte_req(8'h71));
    send_request(byte_req(8'h72));
    send_request(byte_req(8'h73));
    send_request(byte_req(CH_CR));
    drain_results();

    program_editor(1'b1, 32'd5, 1'b0);
    run_random(90);
    drain_results();

    // Every tick times out.
    program_editor(1'b1, 32'd0, 1'b1);
    run_random(55);
    drain_results();

    // Largest limit: the count can never exceed it.
    program_editor(1'b1, 32'hffff_ffff, 1'b0);
    run_random(55);
    drain_results();

    program_editor(1'b0, $urandom, 1'b1);
    run_random(45);
    quiet <= 1'b1;
    run_random(45);
    drain_results();

    if (line_model.fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still owed", $time, line_model.owed_count());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sle_pkg.sv
hdl/sle_ram.sv
hdl/serial_line_editor.sv
hdl/sle_chk.sv
bench/tb_serial_line_editor.sv
